/* src/insertion_sort_engine_assert.svh */
// assertion macros used by the sort engine checker
// no dependencies; include with the bare file name
`ifndef INSERTION_SORT_ENGINE_ASSERT_SVH
`define INSERTION_SORT_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ISE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ISE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ise_pkg.sv */
// shared types for the insertion sort engine
// no dependencies; used by controller, datapath and top level
package ise_pkg;

  localparam int unsigned DataW = 32;

  // controller states
  typedef enum logic [0:0] {
    StFill,
    StDrain
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic insert;     // write the arriving word into the cell row
    logic drop;       // row is full, mark the set as overflowed
    logic shift_out;  // head word taken, shift row toward the head
    logic clear;      // final word taken, reset count and overflow
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;       // every cell holds a word
    logic one_left;   // exactly one word remains
  } status_t;

endpackage

/* src/ise_ctrl.sv */
// controller state machine for the insertion sort engine
// depends on ise_pkg for state, command and status types
module ise_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ise_pkg::status_t  status_i,
  output ise_pkg::cmd_t     cmd_o
);

  ise_pkg::state_e state_q, state_d;
  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid_i && (state_q == ise_pkg::StFill);
  assign out_fire = out_ready_i && (state_q == ise_pkg::StDrain);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ise_pkg::StFill: begin
        if (in_fire && last_i) begin
          state_d = ise_pkg::StDrain;
        end
      end
      ise_pkg::StDrain: begin
        if (out_fire && status_i.one_left) begin
          state_d = ise_pkg::StFill;
        end
      end
      default: state_d = ise_pkg::StFill;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cmd_o.insert      = 1'b0;
    cmd_o.drop        = 1'b0;
    cmd_o.shift_out   = 1'b0;
    cmd_o.clear       = 1'b0;
    unique case (state_q)
      ise_pkg::StFill: begin
        in_ready_o   = 1'b1;
        cmd_o.insert = in_fire && !status_i.full;
        cmd_o.drop   = in_fire && status_i.full;
      end
      ise_pkg::StDrain: begin
        out_valid_o     = 1'b1;
        cmd_o.shift_out = out_fire;
        cmd_o.clear     = out_fire && status_i.one_left;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ise_pkg::StFill;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/ise_datapath.sv */
// row of compare-and-shift cells, word count and overflow flag
// depends on ise_pkg for command and status types
module ise_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ise_pkg::cmd_t                     cmd_i,
  input  logic signed [ise_pkg::DataW-1:0]  value_i,
  output ise_pkg::status_t                  status_o,
  output logic signed [ise_pkg::DataW-1:0]  head_o,
  output logic                              overflow_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic signed [ise_pkg::DataW-1:0] cells_q [DEPTH];
  logic signed [ise_pkg::DataW-1:0] cells_d [DEPTH];
  logic [DEPTH-1:0]                 lt;
  logic [CntW-1:0]                  count_q, count_d;
  logic                             dropped_q, dropped_d;

  // one cell per entry: compare with the arriving word, pick the new content
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ise_pkg::DataW-1:0] ins_src;
    logic signed [ise_pkg::DataW-1:0] drain_src;
    logic                             at_end;

    assign lt[i]  = (CntW'(i) < count_q) && (value_i < cells_q[i]);
    assign at_end = (CntW'(i) == count_q);

    // word that lands here on insert: left neighbor if it moves right
    if (i == 0) begin : g_first
      assign ins_src = value_i;
    end else begin : g_rest
      assign ins_src = lt[i-1] ? cells_q[i-1] : value_i;
    end

    // word that lands here on drain: right neighbor; the last cell keeps its own
    if (i == DEPTH - 1) begin : g_tail
      assign drain_src = cells_q[i];
    end else begin : g_body
      assign drain_src = cells_q[i+1];
    end

    always_comb begin
      cells_d[i] = cells_q[i];
      if (cmd_i.insert && (lt[i] || at_end)) begin
        cells_d[i] = ins_src;
      end else if (cmd_i.shift_out) begin
        cells_d[i] = drain_src;
      end
    end
  end

  // cell row, no reset on payload
  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
  end

  // count and overflow flag
  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.drop) begin
      dropped_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end else if (cmd_i.shift_out) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  assign status_o.full     = (count_q == CntW'(DEPTH));
  assign status_o.one_left = (count_q == CntW'(1));
  assign head_o            = cells_q[0];
  assign overflow_o        = dropped_q;

endmodule

/* src/insertion_sort_engine.sv */
// insertion sort engine: inserts one word per cycle into a sorted cell row,
// then drains the set in ascending order, one word per cycle while out_ready_i is high.
// latency: first result valid the cycle after the last-marked word is taken
// throughput: 1 word in per cycle while filling; results leave while draining
// as the output is ready, input held off during drain
// reset: async active low clears state, count and overflow; cells unreset
module insertion_sort_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [ise_pkg::DataW-1:0]  value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ise_pkg::DataW-1:0]  sorted_value_o,
  output logic                              final_res_o,
  output logic                              overflow_o
);

  ise_pkg::cmd_t    cmd;
  ise_pkg::status_t status;

  // sequencing of fill and drain
  ise_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // cell row and counters
  ise_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (value_i),
    .status_o   (status),
    .head_o     (sorted_value_o),
    .overflow_o (overflow_o)
  );

  // last word of the run: high whenever only one word remains, also while filling
  assign final_res_o = status.one_left;

endmodule

/* src/ise_checker.sv */
// port-level checks for the insertion sort engine, bound to the top level
// depends on insertion_sort_engine_assert.svh
`include "insertion_sort_engine_assert.svh"

module ise_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic last_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic final_res_o,
  input logic overflow_o
);

  // fill and drain never overlap
  `ISE_ASSERT_NOW(a_fill_drain_excl, 1'b1, !(in_ready_o && out_valid_o),
                  "fill and drain overlap")

  // a last word starts the drain
  `ISE_ASSERT_NEXT(a_last_starts_drain, in_valid_i && in_ready_o && last_i, out_valid_o,
                   "no drain after last word")

  // taking the final result reopens the input
  `ISE_ASSERT_NEXT(a_final_reopens, out_valid_o && out_ready_i && final_res_o,
                   in_ready_o && !out_valid_o,
                   "input not reopened after final result")

  // a non-final result is followed by more results with the same overflow flag
  `ISE_ASSERT_NEXT(a_drain_continues, out_valid_o && out_ready_i && !final_res_o,
                   out_valid_o && (overflow_o == $past(overflow_o)),
                   "drain stopped early or overflow changed")

endmodule

bind insertion_sort_engine ise_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .final_res_o (final_res_o),
  .overflow_o  (overflow_o)
);
